// File: hdl/ihaar_pkg.sv
// ----------------------------------------------------------------------------
// ihaar_pkg
// Shared constants, types and command struct for the integer Haar tile
// transform.
// ----------------------------------------------------------------------------
package ihaar_pkg;

  localparam int MAX_WIDTH_DEFAULT  = 8;
  localparam int MAX_HEIGHT_DEFAULT = 8;

  localparam int SAMPLE_W    = 11;
  localparam int DIM_W       = 4;
  localparam int CFG_DATA_W  = 4;
  localparam int CFG_INDEX_W = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MODE        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_HEIGHT = 2'd2;

  // mode codes
  localparam logic MODE_FORWARD = 1'b0;
  localparam logic MODE_INVERSE = 1'b1;

  localparam logic [DIM_W-1:0] TILE_WIDTH_RESET  = 4'd8;
  localparam logic [DIM_W-1:0] TILE_HEIGHT_RESET = 4'd8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // controller to datapath command bundle
  typedef struct packed {
    logic wr_sample;  // write the incoming sample into the tile store
    logic wr_result;  // write the pair unit result into the tile store
    logic rd;         // read the tile store
    logic ld;         // the read feeds the line buffer
    logic sel_high;   // second result of the pair (high or odd)
    logic inverse;    // inverse arithmetic
    logic emit;       // the read feeds the result port
    logic last;       // final element of the tile
  } cmd_t;

endpackage

// File: hdl/integer_haar_2d_tile_transform.sv
// ----------------------------------------------------------------------------
// integer_haar_2d_tile_transform
// One-level integer Haar transform of a tile, forward or inverse, loaded and
// emitted in raster order.
// ----------------------------------------------------------------------------
//  Channel   Ports                           Transaction
//  --------  ------------------------------  ---------------------------------
//  input     start, busy, sample             edge with start high, busy low
//  result    valid, value, last              every edge with valid high
//  config    cfg_write, cfg_index, cfg_data  every edge with cfg_write high
//
//  Loading stores one sample per accepted start; busy stays low until the
//  sample that completes the tile. Then busy is high for both passes and the
//  emission: each line of length L is read from the store, passes a
//  read-latency state, and then takes one store write per result on the
//  single write port; then the n = width*height results emit, one result per
//  cycle, with the final result in the first cycle that busy is low. Reset
//  restores the registers and empties the tile; the store needs no clearing.
//  The receiver cannot stall.
// ----------------------------------------------------------------------------
module integer_haar_2d_tile_transform #(
  parameter int MAX_WIDTH  = ihaar_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = ihaar_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  ihaar_pkg::sample_t                sample,
  output logic                              valid,
  output ihaar_pkg::sample_t                value,
  output logic                              last,
  input  logic                              cfg_write,
  input  logic [ihaar_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ihaar_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int MAXL  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int LW    = $clog2(MAXL);

  logic                        mode;
  logic [ihaar_pkg::DIM_W-1:0] tile_width;
  logic [ihaar_pkg::DIM_W-1:0] tile_height;

  ihaar_pkg::cmd_t cmd;
  logic [AW-1:0]   addr;
  logic [LW-1:0]   slot;
  logic [LW-1:0]   pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= ihaar_pkg::MODE_FORWARD;
      tile_width  <= ihaar_pkg::TILE_WIDTH_RESET;
      tile_height <= ihaar_pkg::TILE_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ihaar_pkg::REG_MODE:        mode        <= cfg_data[0];
        ihaar_pkg::REG_TILE_WIDTH:  tile_width  <= cfg_data;
        ihaar_pkg::REG_TILE_HEIGHT: tile_height <= cfg_data;
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  ihaar_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (mode),
    .tile_width  (tile_width),
    .tile_height (tile_height),
    .busy        (busy),
    .cmd         (cmd),
    .addr        (addr),
    .slot        (slot),
    .pair        (pair)
  );

  ihaar_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .addr   (addr),
    .slot   (slot),
    .pair   (pair),
    .sample (sample),
    .valid  (valid),
    .value  (value),
    .last   (last)
  );

  // results of a tile come out back to back
  assert property (@(posedge clk) disable iff (rst) valid && !last |=> valid)
    else $error("emission gap inside a tile");

  // nothing follows the final result in the next cycle
  assert property (@(posedge clk) disable iff (rst) valid && last |=> !valid)
    else $error("result right after the final element");

  // busy drops exactly as the final result shows
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> valid && last)
    else $error("busy fell without the final result");

  // a result only follows a busy cycle
  assert property (@(posedge clk) disable iff (rst) valid |-> $past(busy))
    else $error("result while idle");

endmodule

// File: hdl/ihaar_dp.sv
// ----------------------------------------------------------------------------
// ihaar_dp
// Datapath: tile store memory, line buffer, Haar pair unit and result
// register.
// ----------------------------------------------------------------------------
module ihaar_dp #(
  parameter int MAX_WIDTH  = ihaar_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = ihaar_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  ihaar_pkg::cmd_t                                cmd,
  input  logic [$clog2(MAX_WIDTH * MAX_HEIGHT)-1:0]      addr,
  input  logic [$clog2((MAX_WIDTH > MAX_HEIGHT) ?
                       MAX_WIDTH : MAX_HEIGHT)-1:0]      slot,
  input  logic [$clog2((MAX_WIDTH > MAX_HEIGHT) ?
                       MAX_WIDTH : MAX_HEIGHT)-1:0]      pair,
  input  ihaar_pkg::sample_t                             sample,
  output logic                                           valid,
  output ihaar_pkg::sample_t                             value,
  output logic                                           last
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int MAXL  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int LW    = $clog2(MAXL);
  localparam int XW    = ihaar_pkg::SAMPLE_W + 2;

  localparam logic signed [XW-1:0] SAT_HI = 13'sd1023;
  localparam logic signed [XW-1:0] SAT_LO = -13'sd1024;
  localparam ihaar_pkg::sample_t   PIX_HI = 11'sd255;
  localparam ihaar_pkg::sample_t   PIX_LO = 11'sd0;

  function automatic ihaar_pkg::sample_t sat11(input logic signed [XW-1:0] v);
    if (v > SAT_HI) return ihaar_pkg::SAMPLE_W'(SAT_HI);
    if (v < SAT_LO) return ihaar_pkg::SAMPLE_W'(SAT_LO);
    return ihaar_pkg::SAMPLE_W'(v);
  endfunction

  ihaar_pkg::sample_t mem [DEPTH];
  ihaar_pkg::sample_t rdata;
  ihaar_pkg::sample_t line_buf [MAXL];
  logic               ld_d;
  logic [LW-1:0]      slot_d;
  logic               valid_r;
  logic               last_r;
  logic               inv_r;

  ihaar_pkg::sample_t     op_a, op_b, result, wdata;
  logic signed [XW-1:0]   ax, bx, sum_ab, sum_adj, fwd_low, fwd_high;
  logic signed [XW-1:0]   hi_inc, inv_even, inv_odd;

  // pick the pair from fixed taps of the line buffer
  always_comb begin
    op_a = line_buf[0];
    op_b = line_buf[1];
    for (int i = 0; i < MAXL / 2; i++) begin
      if (pair == LW'(i)) begin
        op_a = line_buf[2 * i];
        op_b = line_buf[2 * i + 1];
      end
    end
  end

  always_comb begin
    ax       = {{2{op_a[ihaar_pkg::SAMPLE_W-1]}}, op_a};
    bx       = {{2{op_b[ihaar_pkg::SAMPLE_W-1]}}, op_b};
    sum_ab   = ax + bx;
    // truncate toward zero: bias negative sums by one before the shift
    sum_adj  = sum_ab + XW'(sum_ab[XW-1]);
    fwd_low  = sum_adj >>> 1;
    fwd_high = ax - bx;
    hi_inc   = bx + 13'sd1;
    inv_even = ax + (hi_inc >>> 1);
    inv_odd  = ax - (bx >>> 1);
    if (cmd.inverse) begin
      result = cmd.sel_high ? sat11(inv_odd) : sat11(inv_even);
    end else begin
      result = cmd.sel_high ? sat11(fwd_high) : sat11(fwd_low);
    end
    wdata = cmd.wr_sample ? sample : result;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_sample || cmd.wr_result) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    slot_d <= slot;
    last_r <= cmd.last;
    inv_r  <= cmd.inverse;
    if (ld_d) begin
      line_buf[slot_d] <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ld_d    <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      ld_d    <= cmd.ld;
      valid_r <= cmd.emit;
    end
  end

  always_comb begin
    value = rdata;
    if (inv_r) begin
      if (rdata < PIX_LO) begin
        value = PIX_LO;
      end else if (rdata > PIX_HI) begin
        value = PIX_HI;
      end
    end
  end

  assign valid = valid_r;
  assign last  = valid_r & last_r;

endmodule

// File: hdl/ihaar_ctrl.sv
// ----------------------------------------------------------------------------
// ihaar_ctrl
// Controller: tile fill count, pass and line sequencing, store addressing
// and emission.
// ----------------------------------------------------------------------------
module ihaar_ctrl #(
  parameter int MAX_WIDTH  = ihaar_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = ihaar_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic                                      mode,
  input  logic [ihaar_pkg::DIM_W-1:0]               tile_width,
  input  logic [ihaar_pkg::DIM_W-1:0]               tile_height,
  output logic                                      busy,
  output ihaar_pkg::cmd_t                           cmd,
  output logic [$clog2(MAX_WIDTH * MAX_HEIGHT)-1:0] addr,
  output logic [$clog2((MAX_WIDTH > MAX_HEIGHT) ?
                       MAX_WIDTH : MAX_HEIGHT)-1:0] slot,
  output logic [$clog2((MAX_WIDTH > MAX_HEIGHT) ?
                       MAX_WIDTH : MAX_HEIGHT)-1:0] pair
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int MAXL  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int LW    = $clog2(MAXL);
  localparam int LCW   = $clog2(MAXL + 1);
  localparam int WCW   = $clog2(MAX_WIDTH + 1);
  localparam int HCW   = $clog2(MAX_HEIGHT + 1);
  localparam int PW    = LW + WCW + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_WRITE = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t        state;
  logic [AW-1:0] fill;
  logic          second;
  logic [LW-1:0] line_idx;
  logic [LW-1:0] elem;
  logic [LW-1:0] pair_idx;
  logic          sel;
  logic [AW-1:0] emit_idx;

  logic           inverse;
  logic [WCW-1:0] w_eff;
  logic [HCW-1:0] h_eff;
  logic [CW-1:0]  n_items;
  logic [CW-1:0]  fill_inc;
  logic           tile_done;
  logic           pass_col;
  logic [LCW-1:0] len, half, nlines;
  logic           elem_last, pair_last, line_last, emit_last, line_end;
  logic [LCW-1:0] wpos_x, elem_x, slot_x;
  logic [LW-1:0]  pos, major, minor;
  logic [AW-1:0]  lin_addr;

  always_comb begin
    inverse = (mode == ihaar_pkg::MODE_INVERSE);
    // out-of-range sizes clamp to 1..MAX
    if (tile_width == '0) begin
      w_eff = WCW'(1);
    end else if (32'(tile_width) > MAX_WIDTH) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(tile_width);
    end
    if (tile_height == '0) begin
      h_eff = HCW'(1);
    end else if (32'(tile_height) > MAX_HEIGHT) begin
      h_eff = HCW'(MAX_HEIGHT);
    end else begin
      h_eff = HCW'(tile_height);
    end
    n_items   = CW'(w_eff * h_eff);
    fill_inc  = CW'(fill) + CW'(1);
    tile_done = (fill_inc >= n_items);

    // forward runs rows then columns, inverse the other way round
    pass_col = second ^ inverse;
    len      = pass_col ? LCW'(h_eff) : LCW'(w_eff);
    nlines   = pass_col ? LCW'(w_eff) : LCW'(h_eff);
    half     = len >> 1;

    elem_last = (LCW'(elem) == len - LCW'(1));
    pair_last = (LCW'(pair_idx) == half - LCW'(1));
    line_last = (LCW'(line_idx) == nlines - LCW'(1));
    emit_last = (CW'(emit_idx) == n_items - CW'(1));
    line_end  = ((state == S_DRAIN) && (half == '0)) ||
                ((state == S_WRITE) && sel && pair_last);

    // write-back position of the current result within the line
    if (inverse) begin
      wpos_x = (LCW'(pair_idx) << 1) + LCW'(sel);
    end else begin
      wpos_x = sel ? LCW'(pair_idx) + half : LCW'(pair_idx);
    end

    // inverse lines are interleaved on load so each pair sits in adjacent slots
    elem_x = LCW'(elem);
    if (!inverse || (elem_x >= (half << 1))) begin
      slot_x = elem_x;
    end else if (elem_x < half) begin
      slot_x = elem_x << 1;
    end else begin
      slot_x = ((elem_x - half) << 1) + LCW'(1);
    end

    pos      = (state == S_LOAD) ? elem : LW'(wpos_x);
    major    = pass_col ? pos : line_idx;
    minor    = pass_col ? line_idx : pos;
    lin_addr = AW'(PW'(major) * PW'(w_eff) + PW'(minor));
  end

  always_comb begin
    case (state)
      S_IDLE:  addr = fill;
      S_EMIT:  addr = emit_idx;
      default: addr = lin_addr;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.inverse   = inverse;
    cmd.sel_high  = sel;
    case (state)
      S_IDLE: begin
        cmd.wr_sample = start;
      end
      S_LOAD: begin
        cmd.rd = 1'b1;
        cmd.ld = 1'b1;
      end
      S_WRITE: begin
        cmd.wr_result = 1'b1;
      end
      S_EMIT: begin
        cmd.rd   = 1'b1;
        cmd.emit = 1'b1;
        cmd.last = emit_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign slot = LW'(slot_x);
  assign pair = pair_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      second   <= 1'b0;
      line_idx <= '0;
      elem     <= '0;
      pair_idx <= '0;
      sel      <= 1'b0;
      emit_idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            if (tile_done) begin
              fill     <= '0;
              second   <= 1'b0;
              line_idx <= '0;
              elem     <= '0;
              state    <= S_LOAD;
            end else begin
              fill <= fill + AW'(1);
            end
          end
        end
        S_LOAD: begin
          elem <= elem + LW'(1);
          if (elem_last) begin
            elem  <= '0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          pair_idx <= '0;
          sel      <= 1'b0;
          state    <= S_WRITE;
        end
        S_WRITE: begin
          sel <= ~sel;
          if (sel && !pair_last) begin
            pair_idx <= pair_idx + LW'(1);
          end
        end
        S_EMIT: begin
          emit_idx <= emit_idx + AW'(1);
          if (emit_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // advance to the next line, the next pass or the emission
      if (line_end) begin
        sel <= 1'b0;
        if (line_last) begin
          line_idx <= '0;
          if (second) begin
            emit_idx <= '0;
            state    <= S_EMIT;
          end else begin
            second <= 1'b1;
            state  <= S_LOAD;
          end
        end else begin
          line_idx <= line_idx + LW'(1);
          state    <= S_LOAD;
        end
      end
    end
  end

endmodule

// File: tb/tb_integer_haar_2d_tile_transform.sv
// ----------------------------------------------------------------------------
// tb_integer_haar_2d_tile_transform
// Self-checking testbench for the integer Haar tile transform. Tiles are
// loaded over the start/busy handshake. A local model of the tile store,
// both transform directions and the size clamping predicts every emitted
// element, and each result is checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb_integer_haar_2d_tile_transform;
  import ihaar_pkg::*;

  localparam int  CYCLE_LIMIT   = 1000000;
  localparam int  SETTLE_CYCLES = 4;
  localparam int  RANDOM_ITEMS  = 275;
  localparam int  STORE_DEPTH   = 64;
  localparam int  IDLE_PERCENT  = 19;
  // index with no register behind it; writes to it must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    sample_t value;
    logic    last;
  } element_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  sample_t                sample;
  logic                   valid;
  sample_t                value;
  logic                   last;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // model state
  logic              model_mode;
  logic [DIM_W-1:0]  model_width;
  logic [DIM_W-1:0]  model_height;
  sample_t           tile_store [STORE_DEPTH];
  logic [6:0]        tile_fill;
  int                work [STORE_DEPTH];
  element_t          pending_elements [$];

  int  mismatch_count;
  int  cycle_count;
  int  samples_sent;
  bit  gaps_on;

  integer_haar_2d_tile_transform u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .sample    (sample),
    .valid     (valid),
    .value     (value),
    .last      (last),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Transform model
  // --------------------------------------------------------------------------
  function automatic int sat_coef(input int v);
    if (v > 1023) return 1023;
    if (v < -1024) return -1024;
    return v;
  endfunction

  function automatic int floor_half(input int v);
    if (v >= 0) return v / 2;
    return -((-v + 1) / 2);
  endfunction

  function automatic int clamp_dim(input logic [DIM_W-1:0] v);
    if (v < 1) return 1;
    if (v > 8) return 8;
    return int'(v);
  endfunction

  // one 1-D pass over a row or column of the work array
  function automatic void haar_line(input int base, input int stride, input int len,
                                    input bit inverse);
    int line [8];
    int half, i, x, y, p, q, pi, qi;
    half = len / 2;
    for (i = 0; i < len; i++) line[i] = work[(base + i * stride) % STORE_DEPTH];
    for (i = 0; i < half; i++) begin
      if (!inverse) begin
        x  = line[2 * i];
        y  = line[2 * i + 1];
        p  = (x + y) / 2;  // truncates toward zero
        q  = x - y;
        pi = i;
        qi = i + half;
      end else begin
        x  = line[i];
        y  = line[i + half];
        p  = x + floor_half(y + 1);
        q  = x - floor_half(y);
        pi = 2 * i;
        qi = 2 * i + 1;
      end
      work[(base + pi * stride) % STORE_DEPTH] = sat_coef(p);
      work[(base + qi * stride) % STORE_DEPTH] = sat_coef(q);
    end
  endfunction

  function automatic void haar_tile(input int w, input int h, input bit inverse);
    int r;
    if (!inverse) begin
      for (r = 0; r < h; r++) haar_line(r * w, 1, w, 1'b0);
      for (r = 0; r < w; r++) haar_line(r, w, h, 1'b0);
    end else begin
      for (r = 0; r < w; r++) haar_line(r, w, h, 1'b1);
      for (r = 0; r < h; r++) haar_line(r * w, 1, w, 1'b1);
    end
  endfunction

  // store one accepted sample; a completed tile queues its transformed elements
  task automatic absorb_sample(input sample_t s);
    int w, h, n, k, v;
    bit inverse;
    element_t e;
    w = clamp_dim(model_width);
    h = clamp_dim(model_height);
    n = w * h;
    inverse = (model_mode == MODE_INVERSE);
    tile_store[tile_fill[5:0]] = s;
    tile_fill = tile_fill + 7'd1;
    if (int'(tile_fill) < n) return;
    tile_fill = '0;
    for (k = 0; k < STORE_DEPTH; k++) work[k] = tile_store[k];
    haar_tile(w, h, inverse);
    for (k = 0; k < n; k++) begin
      v = work[k];
      if (inverse) begin
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      e.value = sample_t'(v);
      e.last  = (k == n - 1);
      pending_elements.push_back(e);
    end
  endtask

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_MODE:        model_mode   = data[0];
      REG_TILE_WIDTH:  model_width  = data;
      REG_TILE_HEIGHT: model_height = data;
      default: ;
    endcase
  endtask

  task automatic write_shape(input logic mode, input logic [DIM_W-1:0] w,
                             input logic [DIM_W-1:0] h);
    write_reg(REG_MODE, {3'b000, mode});
    write_reg(REG_TILE_WIDTH, w);
    write_reg(REG_TILE_HEIGHT, h);
  endtask

  // start stays high after the transaction; drain drops it
  task automatic send_sample(input sample_t s);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      start = 1'b0;
      @(negedge clk);
    end
    start  = 1'b1;
    sample = s;
    do @(posedge clk); while (busy !== 1'b0);
    samples_sent++;
    absorb_sample(s);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_elements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic sample_t any_sample();
    return sample_t'($urandom_range(0, 2047));
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    if ($urandom_range(0, 99) < 85) return DIM_W'($urandom_range(1, 8));
    return DIM_W'($urandom_range(0, 15));
  endfunction

  // --------------------------------------------------------------------------
  // Checker
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    element_t e;
    if (!rst && valid === 1'b1) begin
      if (pending_elements.size() == 0) begin
        report_mismatch($sformatf("unexpected element value=%0d last=%b", value, last));
      end else begin
        e = pending_elements.pop_front();
        if (value !== e.value)
          report_mismatch($sformatf("value got %0d want %0d", value, e.value));
        if (last !== e.last)
          report_mismatch($sformatf("last got %b want %b", last, e.last));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // full 8x8 forward tile on the reset register values
  task automatic test_default_size();
    int k;
    for (k = 0; k < 64; k++) send_sample(any_sample());
    drain();
  endtask

  // saturating high coefficients and truncation of negative sums
  task automatic test_forward_extremes();
    write_shape(MODE_FORWARD, 4'd2, 4'd2);
    send_sample(11'sd1023);
    send_sample(-11'sd1024);
    send_sample(-11'sd1024);
    send_sample(11'sd1023);
    send_sample(-11'sd3);
    send_sample(11'sd0);
    send_sample(11'sd1023);
    send_sample(11'sd1023);
    drain();
  endtask

  // zero counts as one, above eight counts as eight
  task automatic test_size_clamp();
    write_shape(MODE_FORWARD, 4'd0, 4'd0);
    send_sample(-11'sd5);
    drain();
    write_reg(REG_TILE_WIDTH, 4'd9);
    send_sample(-11'sd1024);
    send_sample(11'sd1023);
    send_sample(11'sd1023);
    send_sample(11'sd1023);
    send_sample(-11'sd7);
    send_sample(11'sd4);
    send_sample(11'sd0);
    send_sample(-11'sd1);
    drain();
  endtask

  // inverse output clamps to 0..255, including the odd trailing element
  task automatic test_inverse_saturation();
    write_shape(MODE_INVERSE, 4'd3, 4'd1);
    send_sample(11'sd200);
    send_sample(11'sd130);
    send_sample(-11'sd7);
    drain();
    write_shape(MODE_INVERSE, 4'd2, 4'd2);
    send_sample(-11'sd300);
    send_sample(11'sd100);
    send_sample(11'sd5);
    send_sample(-11'sd1000);
    drain();
  endtask

  // shrink the tile below the count already held; next sample completes it
  task automatic test_size_change_mid_tile();
    write_shape(MODE_FORWARD, 4'd2, 4'd2);
    send_sample(11'sd77);
    send_sample(-11'sd12);
    drain();
    write_reg(REG_UNUSED, 4'hf);
    write_reg(REG_TILE_WIDTH, 4'd1);
    write_reg(REG_TILE_HEIGHT, 4'd1);
    send_sample(11'sd300);
    drain();
  endtask

  task automatic random_tile(input bit reconfigure);
    int w, h, n, k, cut;
    int vals [STORE_DEPTH];
    bit shaped;
    if (reconfigure) begin
      drain();
      write_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 15)));
      write_reg(REG_TILE_WIDTH, pick_dim());
      write_reg(REG_TILE_HEIGHT, pick_dim());
    end
    w = clamp_dim(model_width);
    h = clamp_dim(model_height);
    n = w * h;
    // mostly pixel tiles; inverse mode gets their forward coefficients
    shaped = ($urandom_range(0, 9) < 7);
    for (k = 0; k < n; k++) vals[k] = shaped ? $urandom_range(0, 255) : int'(any_sample());
    if (shaped && model_mode == MODE_INVERSE) begin
      for (k = 0; k < n; k++) work[k] = vals[k];
      haar_tile(w, h, 1'b0);
      for (k = 0; k < n; k++) vals[k] = work[k];
    end
    cut = (n > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, n - 1) : n;
    for (k = 0; k < cut; k++) send_sample(sample_t'(vals[k]));
    if (cut < n) begin
      drain();
      write_reg(REG_TILE_WIDTH, pick_dim());
      write_reg(REG_TILE_HEIGHT, pick_dim());
      while (tile_fill != 0) send_sample(any_sample());
    end
  endtask

  task automatic test_random_tiles();
    int first;
    first = samples_sent;
    random_tile(1'b1);
    while (samples_sent - first < RANDOM_ITEMS) begin
      // hold the input side busy through a middle stretch
      gaps_on = !((samples_sent - first) > 120 && (samples_sent - first) < 240);
      random_tile($urandom_range(0, 9) < 4);
    end
    gaps_on = 1'b1;
    drain();
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    sample         = '0;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    model_mode     = MODE_FORWARD;
    model_width    = TILE_WIDTH_RESET;
    model_height   = TILE_HEIGHT_RESET;
    tile_fill      = '0;
    mismatch_count = 0;
    samples_sent   = 0;
    gaps_on        = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_size();
    test_forward_extremes();
    test_size_clamp();
    test_inverse_saturation();
    test_size_change_mid_tile();
    test_random_tiles();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_elements.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
